[rtl/core/otsc_pkg.sv]
// Shared types, command codes and helper functions for the thermometer command layer
`timescale 1ns / 1ps

package otsc_pkg;

    // input word: command or data byte plus current temperature
    typedef struct packed {
        logic              kind;
        logic [7:0]        code;
        logic signed [11:0] temp_sixteenths;
    } t_in_word;

    // output word: one result of a command
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        has_byte;
        logic [19:0] busy_us;
        logic [1:0]  status;
        logic        last;
    } t_out_word;

    // function command codes
    localparam logic [7:0] CMD_CONVERT = 8'h44;
    localparam logic [7:0] CMD_COPY    = 8'h48;
    localparam logic [7:0] CMD_WRITE   = 8'h4E;
    localparam logic [7:0] CMD_POWER   = 8'hB4;
    localparam logic [7:0] CMD_RECALL  = 8'hB8;
    localparam logic [7:0] CMD_READ    = 8'hBE;

    // kind codes
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;
    localparam logic [1:0] ST_WDONE = 2'd3;

    // busy time of copy and recall in us
    localparam logic [19:0] NV_BUSY_US = 20'd10000;

    // scratchpad layout
    localparam int          SCRATCH_DEPTH = 9;
    localparam logic [3:0]  POS_TEMP_LSB  = 4'd0;
    localparam logic [3:0]  POS_TEMP_MSB  = 4'd1;
    localparam logic [3:0]  POS_HIGH      = 4'd2;
    localparam logic [3:0]  POS_LOW       = 4'd3;
    localparam logic [3:0]  POS_SETUP     = 4'd4;
    localparam logic [3:0]  POS_LAST_DATA = 4'd7;
    localparam logic [3:0]  POS_CRC       = 4'd8;

    // write session positions
    localparam logic [2:0] WPOS_FIRST = 3'd2;
    localparam logic [2:0] WPOS_FINAL = 3'd4;

    // nonvolatile shadow reset values
    localparam logic [7:0] NV_HIGH_RESET  = 8'h4B;
    localparam logic [7:0] NV_LOW_RESET   = 8'h46;
    localparam logic [7:0] NV_SETUP_RESET = 8'h7F;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic crc_step;
        logic read_step;
        logic read_sel;
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic need_crc;
        logic is_read;
        logic crc_done;
        logic read_done;
    } t_sts;

    // scratchpad contents after reset
    function automatic logic [7:0] scratch_reset(input logic [3:0] pos);
        logic [7:0] v;
        case (pos)
            4'd0:    v = 8'hFF;
            4'd1:    v = 8'h07;
            4'd2:    v = 8'h4B;
            4'd3:    v = 8'h46;
            4'd4:    v = 8'h7F;
            4'd5:    v = 8'hFF;
            4'd6:    v = 8'h01;
            4'd7:    v = 8'h10;
            4'd8:    v = 8'h2F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // conversion time by resolution bits
    function automatic logic [19:0] conv_busy(input logic [1:0] res);
        logic [19:0] v;
        case (res)
            2'd0:    v = 20'd93750;
            2'd1:    v = 20'd187500;
            2'd2:    v = 20'd375000;
            2'd3:    v = 20'd750000;
            default: v = 20'd750000;
        endcase
        return v;
    endfunction

    // one byte of reflected crc-8, polynomial 0x8C, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 8'h8C;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/onewire_temp_sensor_commands.sv]
// Top level of the thermometer function-command layer
//
// Input channel i_valid/o_ready carries one word: a command byte or a write
// data byte (kind), plus the current temperature in sixteenths for convert.
// Output channel o_valid/i_ready carries result words; last marks the final
// word caused by one input word. Read gives nine words (scratchpad bytes 0
// to 8), every other input gives exactly one.
// One word is handled at a time: the block takes a word, executes it in the
// exec state, then for convert, recall and the final write byte runs the crc
// unit over bytes 0 to 7 at one byte per cycle. A single result is presented
// after exec, or after the crc pass; read words follow exec, one per cycle
// while the receiver takes them. When the receiver stalls, the current word
// holds and no new input word is taken. Reset loads the scratchpad and
// nonvolatile shadow with power-up contents and ends any write session.
`timescale 1ns / 1ps

module onewire_temp_sensor_commands (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  otsc_pkg::t_in_word    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output otsc_pkg::t_out_word   o_data
);

    otsc_pkg::t_ctl w_ctl;
    otsc_pkg::t_sts w_sts;

    // sequencing
    otsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ctl   (w_ctl),
        .i_sts   (w_sts)
    );

    // storage and arithmetic
    otsc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .o_data  (o_data),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

endmodule

[rtl/core/otsc_ctrl.sv]
// Controller state machine: sequences execute, crc pass and result delivery
`timescale 1ns / 1ps

module otsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output otsc_pkg::t_ctl     o_ctl,
    input  otsc_pkg::t_sts     i_sts
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_CRC  = 5'b00100,
        S_RESP = 5'b01000,
        S_READ = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_read) begin
                    n_state = S_READ;
                end else if (i_sts.need_crc) begin
                    n_state = S_CRC;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_CRC: begin
                if (i_sts.crc_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (i_ready && i_sts.read_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshake and datapath commands
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_RESP) || (r_state == S_READ);

    always_comb begin
        o_ctl           = '0;
        o_ctl.load      = (r_state == S_IDLE) && i_valid;
        o_ctl.exec      = (r_state == S_EXEC);
        o_ctl.crc_step  = (r_state == S_CRC);
        o_ctl.read_step = (r_state == S_READ) && i_ready && !i_sts.read_done;
        o_ctl.read_sel  = (r_state == S_READ);
    end

endmodule

[rtl/core/otsc_dp.sv]
// Datapath: scratchpad, nonvolatile shadow, write session state and crc unit
`timescale 1ns / 1ps

module otsc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  otsc_pkg::t_in_word    i_data,
    output otsc_pkg::t_out_word   o_data,
    input  otsc_pkg::t_ctl        i_ctl,
    output otsc_pkg::t_sts        o_sts
);

    typedef enum logic [3:0] {
        OP_DATA_IGNORE,
        OP_DATA_WRITE,
        OP_DATA_FINAL,
        OP_CONVERT,
        OP_COPY,
        OP_WRITE,
        OP_POWER,
        OP_RECALL,
        OP_READ,
        OP_UNKNOWN
    } t_op;

    otsc_pkg::t_in_word  r_in;
    otsc_pkg::t_out_word r_res;
    logic [7:0]          r_scratch [otsc_pkg::SCRATCH_DEPTH];
    logic [7:0]          r_nv_high;
    logic [7:0]          r_nv_low;
    logic [7:0]          r_nv_setup;
    logic [2:0]          r_wpos;
    logic                r_wact;
    logic [3:0]          r_idx;
    logic [7:0]          r_crc;

    t_op                 w_op;
    logic [2:0]          w_pos;
    logic [3:0]          w_pos_idx;
    logic [7:0]          w_byte;
    logic [7:0]          n_crc;
    logic [7:0]          w_temp_msb;
    otsc_pkg::t_out_word w_res;

    // capture the accepted input word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in <= i_data;
        end
    end

    // write position, kept inside the session window
    assign w_pos     = ((r_wpos < otsc_pkg::WPOS_FIRST) || (r_wpos > otsc_pkg::WPOS_FINAL))
                       ? otsc_pkg::WPOS_FIRST : r_wpos;
    assign w_pos_idx = {1'b0, w_pos};

    // decode the captured word
    always_comb begin
        if (r_in.kind == otsc_pkg::KIND_DATA) begin
            if (!r_wact) begin
                w_op = OP_DATA_IGNORE;
            end else if (w_pos == otsc_pkg::WPOS_FINAL) begin
                w_op = OP_DATA_FINAL;
            end else begin
                w_op = OP_DATA_WRITE;
            end
        end else begin
            case (r_in.code)
                otsc_pkg::CMD_CONVERT: w_op = OP_CONVERT;
                otsc_pkg::CMD_COPY:    w_op = OP_COPY;
                otsc_pkg::CMD_WRITE:   w_op = OP_WRITE;
                otsc_pkg::CMD_POWER:   w_op = OP_POWER;
                otsc_pkg::CMD_RECALL:  w_op = OP_RECALL;
                otsc_pkg::CMD_READ:    w_op = OP_READ;
                default:               w_op = OP_UNKNOWN;
            endcase
        end
    end

    // shared byte select for crc pass and readout
    assign w_byte     = r_scratch[r_idx];
    assign n_crc      = otsc_pkg::crc8_byte(r_crc, w_byte);
    assign w_temp_msb = {{4{r_in.temp_sixteenths[11]}}, r_in.temp_sixteenths[11:8]};

    // scratchpad, shadow, session and crc state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < otsc_pkg::SCRATCH_DEPTH; i++) begin
                r_scratch[i] <= otsc_pkg::scratch_reset(4'(i));
            end
            r_nv_high  <= otsc_pkg::NV_HIGH_RESET;
            r_nv_low   <= otsc_pkg::NV_LOW_RESET;
            r_nv_setup <= otsc_pkg::NV_SETUP_RESET;
            r_wpos     <= otsc_pkg::WPOS_FIRST;
            r_wact     <= 1'b0;
            r_idx      <= '0;
            r_crc      <= '0;
        end else begin
            if (i_ctl.exec) begin
                r_idx <= '0;
                r_crc <= '0;
                // a command ends the session, write opens a new one
                if (r_in.kind == otsc_pkg::KIND_CMD) begin
                    r_wact <= (w_op == OP_WRITE);
                end
                case (w_op)
                    OP_DATA_WRITE: begin
                        r_scratch[w_pos_idx] <= r_in.code;
                        r_wpos               <= w_pos + 3'd1;
                    end
                    OP_DATA_FINAL: begin
                        r_scratch[w_pos_idx] <= r_in.code;
                        r_wact               <= 1'b0;
                    end
                    OP_CONVERT: begin
                        r_scratch[otsc_pkg::POS_TEMP_LSB] <= r_in.temp_sixteenths[7:0];
                        r_scratch[otsc_pkg::POS_TEMP_MSB] <= w_temp_msb;
                    end
                    OP_COPY: begin
                        r_nv_high  <= r_scratch[otsc_pkg::POS_HIGH];
                        r_nv_low   <= r_scratch[otsc_pkg::POS_LOW];
                        r_nv_setup <= r_scratch[otsc_pkg::POS_SETUP];
                    end
                    OP_WRITE: begin
                        r_wpos <= otsc_pkg::WPOS_FIRST;
                    end
                    OP_RECALL: begin
                        r_scratch[otsc_pkg::POS_HIGH]  <= r_nv_high;
                        r_scratch[otsc_pkg::POS_LOW]   <= r_nv_low;
                        r_scratch[otsc_pkg::POS_SETUP] <= r_nv_setup;
                    end
                    default: begin
                    end
                endcase
            end
            // one scratchpad byte per cycle through the crc
            if (i_ctl.crc_step) begin
                r_crc <= n_crc;
                r_idx <= r_idx + 4'd1;
                if (r_idx == otsc_pkg::POS_LAST_DATA) begin
                    r_scratch[otsc_pkg::POS_CRC] <= n_crc;
                end
            end
            if (i_ctl.read_step) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // single result word for every input word other than read
    always_comb begin
        w_res      = '0;
        w_res.last = 1'b1;
        case (w_op)
            OP_DATA_FINAL: w_res.status = otsc_pkg::ST_WDONE;
            OP_CONVERT: begin
                w_res.status  = otsc_pkg::ST_BUSY;
                w_res.busy_us = otsc_pkg::conv_busy(r_scratch[otsc_pkg::POS_SETUP][6:5]);
            end
            OP_COPY, OP_RECALL: begin
                w_res.status  = otsc_pkg::ST_BUSY;
                w_res.busy_us = otsc_pkg::NV_BUSY_US;
            end
            OP_UNKNOWN:    w_res.status = otsc_pkg::ST_UNSUP;
            default:       w_res.status = otsc_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_res <= w_res;
        end
    end

    // output word: readout byte or the stored result
    always_comb begin
        if (i_ctl.read_sel) begin
            o_data          = '0;
            o_data.tx_byte  = w_byte;
            o_data.has_byte = 1'b1;
            o_data.status   = otsc_pkg::ST_OK;
            o_data.last     = (r_idx == otsc_pkg::POS_CRC);
        end else begin
            o_data = r_res;
        end
    end

    // status to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.need_crc  = (w_op == OP_DATA_FINAL) || (w_op == OP_CONVERT)
                          || (w_op == OP_RECALL);
        o_sts.is_read   = (w_op == OP_READ);
        o_sts.crc_done  = (r_idx == otsc_pkg::POS_LAST_DATA);
        o_sts.read_done = (r_idx == otsc_pkg::POS_CRC);
    end

endmodule

[rtl/core/otsc_checker.sv]
// Port-level checks for the thermometer command layer, bound to the top level
`timescale 1ns / 1ps

module otsc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input otsc_pkg::t_out_word  o_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // no new input word while results are pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result is pending");

    // results without a byte are single words
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.has_byte |-> o_data.last && o_data.tx_byte == 8'd0)
        else $error("non-read result not single");

    // readout words carry no busy time and ok status
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.has_byte |-> o_data.busy_us == 20'd0
        && o_data.status == otsc_pkg::ST_OK)
        else $error("readout word with busy or status set");

    // busy status always carries a time, other statuses none
    a_busy_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.status == otsc_pkg::ST_BUSY) == (o_data.busy_us != 20'd0)))
        else $error("busy time does not match status");

endmodule

bind onewire_temp_sensor_commands otsc_checker u_otsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
